[rtl/core/bdq_pkg.sv]
// Shared constants, codes and types for the bounded deque engine.
// No dependencies; imported by every module of the block.
package bdq_pkg;

   // Storage geometry
   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int IDX_W      = $clog2(DEPTH);

   // Field widths of the request and response items
   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 3;
   localparam int OCC_W    = 5;

   // Request tdata layout: cmd, value, position (lowest bits first)
   localparam int REQ_VALUE_LSB = CMD_W;
   localparam int REQ_POS_LSB   = CMD_W + VALUE_W;
   localparam int REQ_BITS      = CMD_W + VALUE_W + POS_W;
   localparam int REQ_TDATA_W   = ((REQ_BITS + 7) / 8) * 8;

   // Response tdata layout: status, read_value, occupancy
   localparam int RSP_VALUE_LSB = STATUS_W;
   localparam int RSP_OCC_LSB   = STATUS_W + VALUE_W;
   localparam int RSP_BITS      = STATUS_W + VALUE_W + OCC_W;
   localparam int RSP_TDATA_W   = ((RSP_BITS + 7) / 8) * 8;

   // Command codes; code 7 is a no-op
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_REMOVE     = 3'd4,
      CMD_READ       = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   // Status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK        = 3'd0,
      STS_EMPTY     = 3'd1,
      STS_FULL      = 3'd2,
      STS_NOT_FOUND = 3'd3,
      STS_RANGE     = 3'd4
   } status_type;

   // Per-cell data move
   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_LOAD = 2'd1,
      OP_PREV = 2'd2,
      OP_NEXT = 2'd3
   } cell_op_type;

   // Control bundle from the sequencer to one cell
   typedef struct packed {
      cell_op_type op;
      logic        cmp_en;
   } cell_ctrl_type;

endpackage

[rtl/core/bdq_cell.sv]
// One storage cell of the deque chain: holds a word, takes a neighbor's word
// or a new word, and registers an equality compare. Depends on bdq_pkg.
module bdq_cell
   import bdq_pkg::*;
(
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] prev_data,
   input  logic [DATA_WIDTH-1:0] next_data,
   input  logic [DATA_WIDTH-1:0] load_data,
   input  logic [DATA_WIDTH-1:0] key,
   output logic [DATA_WIDTH-1:0] data,
   output logic                  match
);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;
   logic                  match_ff;
   logic                  match_in;

   // Select the next word for this cell
   always_comb begin
      case (ctrl.op)
         OP_LOAD: entry_in = load_data;
         OP_PREV: entry_in = prev_data;
         OP_NEXT: entry_in = next_data;
         default: entry_in = entry_ff;
      endcase
      match_in = ctrl.cmp_en ? (entry_ff == key) : match_ff;
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign data  = entry_ff;
   assign match = match_ff;

endmodule

[rtl/core/bounded_deque_engine_core.sv]
// Top level of the bounded deque engine: stream handshake, sequencer and
// the chain of bdq_cell storage cells. Depends on bdq_pkg and bdq_cell.
//
//  channel | dir | handshake            | payload (tdata, lowest bits first)
//  req     | in  | req_tvalid/req_tready | cmd[2:0] value[34:3] position[38:35]
//  rsp     | out | rsp_tvalid/rsp_tready | status[2:0] read_value[34:3] occupancy[39:35]
//
// Every command but remove is done in S_IDLE; a remove goes on to S_DROP: the
// cells register their compares in S_IDLE, the first hit is dropped in S_DROP.
// The response sits in one output register; a new request is taken while the
// sequencer is in S_IDLE and that register is empty or being drained in the same cycle.
// Reset clears the count, the response valid and the sequencer; stored words are kept.
module bounded_deque_engine_core
   import bdq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // cmd, value, position
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // status, read_value, occupancy
);

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_DROP = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      fill_count_ff, fill_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic                  req_accept;
   logic                  load_rsp;
   cmd_type               req_cmd;
   logic [VALUE_W-1:0]    req_value;
   logic [POS_W-1:0]      req_pos;
   logic [DATA_WIDTH-1:0] load_word;

   cell_ctrl_type         cell_ctrl [DEPTH];
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]      cell_match;
   logic [DEPTH-1:0]      cell_valid;
   logic [DEPTH-1:0]      hit;
   logic [DEPTH-1:0]      first_hit;
   logic [DEPTH-1:0]      shift_mask;
   logic                  full;
   logic                  empty;
   logic                  read_ok;

   // Request field unpacking
   assign req_cmd   = cmd_type'(req_tdata[CMD_W-1:0]);
   assign req_value = req_tdata[REQ_VALUE_LSB +: VALUE_W];
   assign req_pos   = req_tdata[REQ_POS_LSB +: POS_W];
   assign load_word = req_value[DATA_WIDTH-1:0];

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign full    = (fill_count_ff == CNT_W'(DEPTH));
   assign empty   = (fill_count_ff == '0);
   assign read_ok = (CNT_W'(req_pos) < fill_count_ff);

   // Occupied slots, and the first live hit of a remove with the slots it shifts
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         cell_valid[k] = (CNT_W'(k) < fill_count_ff);
      end
      hit        = cell_match & cell_valid;
      first_hit  = hit & (~hit + DEPTH'(1));
      shift_mask = ~(first_hit - DEPTH'(1));
   end

   // Cell chain
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] prev_w;
      logic [DATA_WIDTH-1:0] next_w;

      if (g == 0) begin : g_head
         assign prev_w = load_word;
      end else begin : g_body
         assign prev_w = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign next_w = cell_data[g];
      end else begin : g_inner
         assign next_w = cell_data[g+1];
      end

      bdq_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[g]),
         .prev_data (prev_w),
         .next_data (next_w),
         .load_data (load_word),
         .key       (load_word),
         .data      (cell_data[g]),
         .match     (cell_match[g])
      );
   end

   // Sequencer: cell moves, count update, response contents
   always_comb begin
      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      load_rsp      = 1'b0;
      rsp_status_in = STS_OK;
      rsp_value_in  = '0;
      for (int k = 0; k < DEPTH; k++) begin
         cell_ctrl[k] = '{op: OP_HOLD, cmp_en: 1'b0};
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               load_rsp = 1'b1;
               case (req_cmd)
                  CMD_PUSH_FRONT: begin
                     if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        for (int k = 0; k < DEPTH; k++) begin
                           cell_ctrl[k].op = (k == 0) ? OP_LOAD : OP_PREV;
                        end
                        fill_count_in = fill_count_ff + CNT_W'(1);
                     end
                  end
                  CMD_PUSH_BACK: begin
                     if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        for (int k = 0; k < DEPTH; k++) begin
                           if (fill_count_ff == CNT_W'(k)) begin
                              cell_ctrl[k].op = OP_LOAD;
                           end
                        end
                        fill_count_in = fill_count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT: begin
                     if (empty) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        for (int k = 0; k < DEPTH; k++) begin
                           cell_ctrl[k].op = OP_NEXT;
                        end
                        fill_count_in = fill_count_ff - CNT_W'(1);
                     end
                  end
                  CMD_POP_BACK: begin
                     if (empty) begin
                        rsp_status_in = STS_EMPTY;
                     end else begin
                        fill_count_in = fill_count_ff - CNT_W'(1);
                     end
                  end
                  CMD_REMOVE: begin
                     // compare this cycle, drop next cycle
                     load_rsp = 1'b0;
                     state_in = S_DROP;
                     for (int k = 0; k < DEPTH; k++) begin
                        cell_ctrl[k].cmp_en = 1'b1;
                     end
                  end
                  CMD_READ: begin
                     if (read_ok) begin
                        rsp_value_in = VALUE_W'(cell_data[IDX_W'(req_pos)]);
                     end else begin
                        rsp_status_in = STS_RANGE;
                     end
                  end
                  CMD_CLEAR: begin
                     fill_count_in = '0;
                  end
                  default: begin
                     // unused code: no operation
                  end
               endcase
            end
         end
         S_DROP: begin
            load_rsp = 1'b1;
            state_in = S_IDLE;
            if (hit == '0) begin
               rsp_status_in = STS_NOT_FOUND;
            end else begin
               for (int k = 0; k < DEPTH; k++) begin
                  if (shift_mask[k]) begin
                     cell_ctrl[k].op = OP_NEXT;
                  end
               end
               fill_count_in = fill_count_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_occ_in = OCC_W'(fill_count_in);
   end

   // Output register valid
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_occ_ff    <= rsp_occ_in;
      end
   end

   // Response packing
   always_comb begin
      rsp_tdata                              = '0;
      rsp_tdata[STATUS_W-1:0]                = rsp_status_ff;
      rsp_tdata[RSP_VALUE_LSB +: VALUE_W]    = rsp_value_ff;
      rsp_tdata[RSP_OCC_LSB +: OCC_W]        = rsp_occ_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/core/bdq_checker.sv]
// Port-level checks for the bounded deque engine, bound to the top level.
// Depends on bdq_pkg and bounded_deque_engine_core.
module bdq_checker
   import bdq_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [CMD_W-1:0]    chk_cmd;
   logic [STATUS_W-1:0] chk_status;
   logic [VALUE_W-1:0]  chk_value;
   logic [OCC_W-1:0]    chk_occ;

   assign chk_cmd    = req_tdata[CMD_W-1:0];
   assign chk_status = rsp_tdata[STATUS_W-1:0];
   assign chk_value  = rsp_tdata[RSP_VALUE_LSB +: VALUE_W];
   assign chk_occ    = rsp_tdata[RSP_OCC_LSB +: OCC_W];

   // A stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // Occupancy stays within the storage depth
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> chk_occ <= OCC_W'(DEPTH))
      else $error("occupancy beyond depth");

   // Read word is zero unless the status is ok
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (chk_status != STS_OK) |-> chk_value == '0)
      else $error("nonzero read word on failed transaction");

   // Every command but remove answers in the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (chk_cmd != CMD_REMOVE) |=> rsp_tvalid)
      else $error("missing response after single-cycle command");

   // A remove occupies the engine for its drop cycle
   a_remove_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (chk_cmd == CMD_REMOVE) |=> !req_tready ##1 rsp_tvalid)
      else $error("remove sequencing broken");

endmodule

bind bounded_deque_engine_core bdq_checker u_bdq_checker (.*);
